FILE: src/sbbm_pkg.sv
package sbbm_pkg;

    localparam int BIN_VAL_W  = 24;
    localparam int MAG_W      = 24;
    localparam int ACC_W      = 28;
    localparam int BAND_W     = 5;
    localparam int LEVEL_W    = 7;
    localparam int EDGE_W     = 9;
    localparam int RECIP_W    = 17;
    localparam int MEM_W      = 23;
    localparam int MA_W       = 29;
    localparam int MB_W       = 27;
    localparam int PROD_W     = MA_W + MB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TOTAL_BANDS = 32;

    typedef logic signed [BIN_VAL_W-1:0] t_bin;
    typedef logic [BAND_W-1:0]           t_band;
    typedef logic [LEVEL_W-1:0]          t_level;
    typedef logic [2:0]                  t_op;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd4;

    localparam logic        SMOOTH_RST = 1'b1;
    localparam logic [15:0] DECAY_RST  = 16'd60293;
    localparam logic [15:0] SENS_RST   = 16'd1150;
    localparam logic [15:0] COEFF_RST  = 16'd4260;
    localparam t_band       CENTER_RST = 5'd8;

    localparam t_level LEVEL_MAX = 7'd100;

    localparam t_op OP_SQ   = 3'd0;
    localparam t_op OP_GAIN = 3'd1;
    localparam t_op OP_MEAN = 3'd2;
    localparam t_op OP_T1   = 3'd3;
    localparam t_op OP_TGT  = 3'd4;
    localparam t_op OP_DEC  = 3'd5;

    localparam logic [EDGE_W-1:0] BAND_EDGES [0:TOTAL_BANDS] = '{
        9'd6,   9'd7,   9'd8,   9'd9,   9'd10,  9'd11,  9'd13,  9'd15,
        9'd17,  9'd20,  9'd23,  9'd27,  9'd31,  9'd36,  9'd42,  9'd49,
        9'd57,  9'd66,  9'd76,  9'd88,  9'd101, 9'd116, 9'd133, 9'd152,
        9'd173, 9'd196, 9'd221, 9'd248, 9'd277, 9'd295, 9'd305, 9'd312,
        9'd320
    };

    // rounded q1.16 reciprocal of each band width
    localparam logic [RECIP_W-1:0] BAND_RECIP [0:TOTAL_BANDS-1] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd32768,
        17'd32768, 17'd32768, 17'd21845, 17'd21845, 17'd16384, 17'd16384,
        17'd13107, 17'd10923, 17'd9362,  17'd8192,  17'd7282,  17'd6554,
        17'd5461,  17'd5041,  17'd4369,  17'd3855,  17'd3449,  17'd3121,
        17'd2849,  17'd2621,  17'd2427,  17'd2260,  17'd3641,  17'd6554,
        17'd9362,  17'd8192
    };

    typedef struct packed {
        logic take;
        logic step;
        logic mul;
        t_op  op;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic band_end;
        logic out_free;
    } t_stat;

endpackage

FILE: src/sbbm_in_if.sv
interface sbbm_in_if;
    import sbbm_pkg::*;

    logic valid;
    logic ready;
    t_bin bin_value;
    logic frame_start;

    modport source (output valid, output bin_value, output frame_start, input ready);
    modport sink (input valid, input bin_value, input frame_start, output ready);
endinterface

FILE: src/sbbm_out_if.sv
interface sbbm_out_if;
    import sbbm_pkg::*;

    logic   valid;
    logic   ready;
    t_band  bar_index;
    t_level bar_level;
    logic   last_bar;

    modport source (output valid, output bar_index, output bar_level, output last_bar,
                    input ready);
    modport sink (input valid, input bar_index, input bar_level, input last_bar,
                  output ready);
endinterface

FILE: src/spectrum_band_bar_meter_unit.sv
// Spectrum band bar meter: takes one spectrum bin per input beat (frame_start marks bin 0),
// sums bin magnitudes over fixed log-spaced bands and, when a band closes, emits one bar
// beat with the scaled, clamped and optionally decay-smoothed level in percent. A bin that
// does not close a band is captured, then updates the band. One that closes a band also uses
// one shared 29x27 multiplier for six products in turn: distance squared, curve gain, band
// mean, sensitivity product, target and decayed level, and waits for the output register to
// drain. Bar levels sit in flip-flops cleared by reset, so the block is ready right after
// reset. The user must write configuration only while idle; the block does not enforce it.
module spectrum_band_bar_meter_unit #(
    parameter int NUM_BARS      = 32,
    parameter int SPECTRUM_BINS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sbbm_in_if.sink                             i_in,
    sbbm_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [sbbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbbm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sbbm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sbbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sbbm_dp #(
        .NUM_BARS      (NUM_BARS),
        .SPECTRUM_BINS (SPECTRUM_BINS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_bin_value   (i_in.bin_value),
        .i_frame_start (i_in.frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_bar_index   (o_out.bar_index),
        .o_bar_level   (o_out.bar_level),
        .o_last_bar    (o_out.last_bar)
    );

endmodule

FILE: src/sbbm_ctrl.sv
module sbbm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sbbm_pkg::t_stat i_stat,
    output sbbm_pkg::t_cmd  o_cmd
);
    import sbbm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STEP = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_GAIN = 4'd3;
    localparam logic [3:0] S_MEAN = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_TGT  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_stat.band_end ? S_SQ : S_IDLE;
            end
            S_SQ: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_SQ;
                n_state   = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_GAIN;
                n_state   = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_MEAN;
                n_state   = S_T1;
            end
            S_T1: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_T1;
                n_state   = S_TGT;
            end
            S_TGT: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_TGT;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.mul = 1'b1;
                o_cmd.op  = OP_DEC;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: src/sbbm_dp.sv
module sbbm_dp #(
    parameter int NUM_BARS      = 32,
    parameter int SPECTRUM_BINS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbbm_pkg::t_cmd                      i_cmd,
    output sbbm_pkg::t_stat                     o_stat,
    input  sbbm_pkg::t_bin                      i_bin_value,
    input  logic                                i_frame_start,
    input  logic                                i_cfg_we,
    input  logic [sbbm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output sbbm_pkg::t_band                     o_bar_index,
    output sbbm_pkg::t_level                    o_bar_level,
    output logic                                o_last_bar
);
    import sbbm_pkg::*;

    localparam int    BIN_W     = $clog2(SPECTRUM_BINS);
    localparam int    BAR_IDX_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam t_band BAND_MAX  = BAND_W'(NUM_BARS - 1);

    // configuration
    logic        r_smooth;
    logic [15:0] r_decay;
    logic [15:0] r_sens;
    logic [15:0] r_coeff;
    t_band       r_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= SMOOTH_RST;
            r_decay  <= DECAY_RST;
            r_sens   <= SENS_RST;
            r_coeff  <= COEFF_RST;
            r_center <= CENTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SMOOTH: r_smooth <= i_cfg_data[0];
                REG_DECAY:  r_decay  <= i_cfg_data;
                REG_SENS:   r_sens   <= i_cfg_data;
                REG_COEFF:  r_coeff  <= i_cfg_data;
                REG_CENTER: r_center <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input beat capture
    logic [MAG_W-1:0] w_mag;
    logic [MAG_W-1:0] r_mag;
    logic             r_fs;

    assign w_mag = i_bin_value[BIN_VAL_W-1] ? (MAG_W'(0) - $unsigned(i_bin_value))
                                             : $unsigned(i_bin_value);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mag <= w_mag;
            r_fs  <= i_frame_start;
        end
    end

    // band tracking
    logic [BIN_W-1:0] r_bin_cnt;
    t_band            r_band_cnt;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_acc_snap;
    t_band            r_cur_band;

    logic [BIN_W-1:0] w_cnt;
    t_band            w_band;
    logic [ACC_W-1:0] w_acc0;
    logic [ACC_W-1:0] w_acc_sum;
    logic [BIN_W-1:0] w_lo;
    logic [BIN_W-1:0] w_hi;
    logic             w_inband;
    logic             w_end;

    assign w_cnt     = r_fs ? '0 : r_bin_cnt;
    assign w_band    = r_fs ? '0 : r_band_cnt;
    assign w_acc0    = r_fs ? '0 : r_acc;
    assign w_acc_sum = w_acc0 + ACC_W'(r_mag);
    assign w_lo      = BIN_W'(BAND_EDGES[6'(w_band)]);
    assign w_hi      = BIN_W'(BAND_EDGES[6'(w_band) + 6'd1]);
    assign w_inband  = (w_cnt >= w_lo) && (w_cnt < w_hi);
    assign w_end     = w_inband && (w_cnt == (w_hi - BIN_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt  <= '0;
            r_band_cnt <= '0;
            r_acc      <= '0;
        end else if (i_cmd.step) begin
            r_bin_cnt  <= (w_cnt < BIN_W'(SPECTRUM_BINS - 1)) ? w_cnt + BIN_W'(1) : w_cnt;
            r_band_cnt <= (w_end && (w_band < BAND_MAX)) ? w_band + BAND_W'(1) : w_band;
            r_acc      <= w_end ? '0 : (w_inband ? w_acc_sum : w_acc0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_acc_snap <= w_acc_sum;
            r_cur_band <= w_band;
        end
    end

    // bar levels, q7.16
    logic [MEM_W-1:0] r_bar_mem [NUM_BARS];
    logic [MEM_W-1:0] w_mem_rd;

    assign w_mem_rd = r_bar_mem[r_cur_band[BAR_IDX_W-1:0]];

    // shared multiplier
    logic [MA_W-1:0]   w_ma;
    logic [MB_W-1:0]   w_mb;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] r_prod;
    t_band             w_dabs;
    logic [MB_W-1:0]   r_gain;
    logic              r_early;
    t_level            r_target;
    logic [MEM_W-1:0]  r_mem;

    assign w_dabs = (r_cur_band >= r_center) ? (r_cur_band - r_center)
                                             : (r_center - r_cur_band);

    always_comb begin
        case (i_cmd.op)
            OP_SQ: begin
                w_ma = MA_W'(w_dabs);
                w_mb = MB_W'(w_dabs);
            end
            OP_GAIN: begin
                w_ma = MA_W'(r_coeff);
                w_mb = MB_W'(r_prod[9:0]);
            end
            OP_MEAN: begin
                w_ma = MA_W'(r_acc_snap);
                w_mb = MB_W'(BAND_RECIP[r_cur_band]);
            end
            OP_T1: begin
                w_ma = r_prod[44:16];
                w_mb = MB_W'(r_sens);
            end
            OP_TGT: begin
                w_ma = MA_W'(r_prod[22:0]);
                w_mb = r_gain;
            end
            OP_DEC: begin
                w_ma = MA_W'(w_mem_rd);
                w_mb = MB_W'(r_decay);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            case (i_cmd.op)
                OP_MEAN: begin
                    r_gain <= MB_W'(17'h10000) + MB_W'(r_prod[25:0]);
                end
                OP_TGT: begin
                    r_early <= (r_prod[PROD_W-1:16] >= 40'd100);
                end
                OP_DEC: begin
                    r_target <= (r_early || (r_prod[PROD_W-1:32] > 24'd100))
                                ? LEVEL_MAX : r_prod[38:32];
                    r_mem    <= w_mem_rd;
                end
                default: begin
                end
            endcase
        end
    end

    // smoothing and result
    logic [MEM_W-1:0] w_tq;
    logic [MEM_W-1:0] w_dec;
    logic [MEM_W-1:0] w_new;
    t_level           w_level;

    assign w_tq    = {r_target, 16'h0000};
    assign w_dec   = r_prod[38:16];
    assign w_new   = (w_tq >= r_mem) ? w_tq : ((w_dec < w_tq) ? w_tq : w_dec);
    assign w_level = r_smooth ? w_new[MEM_W-1:16] : r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BARS; i++) begin
                r_bar_mem[i] <= '0;
            end
        end else if (i_cmd.emit && r_smooth) begin
            r_bar_mem[r_cur_band[BAR_IDX_W-1:0]] <= w_new;
        end
    end

    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_bar_index <= r_cur_band;
            o_bar_level <= w_level;
            o_last_bar  <= (r_cur_band == BAND_MAX);
        end
    end

    assign o_out_valid     = r_ov;
    assign o_stat.band_end = w_end;
    assign o_stat.out_free = !r_ov || i_out_ready;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bar_level <= LEVEL_MAX))
        else $error("bar level above full scale");

    a_last_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_bar == (o_bar_index == BAND_MAX)))
        else $error("last bar flag does not match bar index");

    a_band_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_band_cnt <= BAND_MAX)
        else $error("band counter past last band");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_out_valid)
        else $error("finished bar not presented");

    a_early_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && (i_cmd.op == OP_DEC) && r_early) |=> (r_target == LEVEL_MAX))
        else $error("early clamp lost");

endmodule
